### hw/rtl/lsd_pkg.sv
`default_nettype none
package lsd_pkg;

   // Fixed field widths
   localparam int KEY_W      = 31;
   localparam int TAG_W      = 16;
   localparam int DIG_W      = 4;
   localparam int RADIX      = 10;
   localparam int MAX_DIGITS = 10;

   // Divide by ten: (q * RECIP_10) >> RECIP_SHIFT, exact for any 32-bit q
   localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;
   localparam int          PROD_W      = KEY_W + 32;

   typedef logic [KEY_W-1:0] key_type;

   localparam key_type POW10 [MAX_DIGITS] = '{
      31'd1, 31'd10, 31'd100, 31'd1000, 31'd10000, 31'd100000, 31'd1000000,
      31'd10000000, 31'd100000000, 31'd1000000000
   };

   typedef struct packed {
      logic [KEY_W-1:0] sort_key;
      logic [TAG_W-1:0] record_tag;
      logic             is_last;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] sorted_key;
      logic [TAG_W-1:0] sorted_tag;
      logic             end_of_run;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_COUNT,
      ST_PREFIX,
      ST_SCATTER,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   // Bucket counter commands
   typedef struct packed {
      logic             clear;
      logic             bump;
      logic             scan;
      logic [DIG_W-1:0] sel;
   } bkt_ctl_type;

   // Decimal digit count of a key; zero counts as one digit
   function automatic logic [DIG_W-1:0] digits_of(key_type k);
      logic [DIG_W-1:0] d;
      d = DIG_W'(1);
      for (int n = 1; n < MAX_DIGITS; n++) begin
         if (k >= POW10[n]) d = d + DIG_W'(1);
      end
      return d;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/lsd_ram.sv
`default_nettype none
module lsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                        wdata,
   input  wire logic                                    re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port; read data holds while re is low
   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

### hw/rtl/lsd_digit.sv
`default_nettype none
module lsd_digit #(
   parameter int PW = 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire logic [lsd_pkg::KEY_W-1:0]      in_q,
   input  wire logic [PW-1:0]                  in_pay,
   output logic                                out_valid,
   output logic      [lsd_pkg::DIG_W-1:0]      out_digit,
   output logic      [lsd_pkg::KEY_W-1:0]      out_q,
   output logic      [PW-1:0]                  out_pay
);

   localparam int QW = lsd_pkg::PROD_W - lsd_pkg::RECIP_SHIFT;

   logic [lsd_pkg::PROD_W-1:0] prod_in, prod_ff;
   logic [lsd_pkg::KEY_W-1:0]  q_ff;
   logic [PW-1:0]              pay_ff;
   logic                       valid_ff;
   logic [QW-1:0]              quot;

   // Reciprocal multiply, registered before the digit is formed
   assign prod_in = lsd_pkg::PROD_W'(in_q) * lsd_pkg::PROD_W'(lsd_pkg::RECIP_10);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      prod_ff <= prod_in;
      q_ff    <= in_q;
      pay_ff  <= in_pay;
   end

   // digit = q - 10*(q/10); only the low four bits matter
   assign quot      = prod_ff[lsd_pkg::PROD_W-1:lsd_pkg::RECIP_SHIFT];
   assign out_digit = q_ff[3:0] - {quot[0], 3'b000} - {quot[2:0], 1'b0};
   assign out_q     = lsd_pkg::KEY_W'(quot);
   assign out_pay   = pay_ff;
   assign out_valid = valid_ff;

endmodule
`default_nettype wire

### hw/rtl/lsd_bucket.sv
`default_nettype none
module lsd_bucket #(
   parameter int CW = 7
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lsd_pkg::bkt_ctl_type ctl,
   output logic      [CW-1:0]        start_val
);

   logic [CW-1:0] count_ff [lsd_pkg::RADIX];
   logic [CW-1:0] count_in [lsd_pkg::RADIX];
   logic [CW-1:0] acc_ff, acc_in;

   // Current count (or start slot after the scan) of the selected bucket
   always_comb begin
      start_val = '0;
      for (int b = 0; b < lsd_pkg::RADIX; b++) begin
         if (ctl.sel == lsd_pkg::DIG_W'(b)) start_val = count_ff[b];
      end
   end

   // Clear, count up, or turn counts into start slots one bucket a cycle
   always_comb begin
      acc_in = acc_ff;
      for (int b = 0; b < lsd_pkg::RADIX; b++) count_in[b] = count_ff[b];
      if (ctl.clear) begin
         acc_in = '0;
         for (int b = 0; b < lsd_pkg::RADIX; b++) count_in[b] = '0;
      end else if (ctl.bump) begin
         for (int b = 0; b < lsd_pkg::RADIX; b++) begin
            if (ctl.sel == lsd_pkg::DIG_W'(b)) count_in[b] = count_ff[b] + CW'(1);
         end
      end else if (ctl.scan) begin
         for (int b = 0; b < lsd_pkg::RADIX; b++) begin
            if (ctl.sel == lsd_pkg::DIG_W'(b)) begin
               count_in[b] = acc_ff;
               acc_in      = acc_ff + count_ff[b];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         for (int b = 0; b < lsd_pkg::RADIX; b++) count_ff[b] <= '0;
      end else begin
         acc_ff <= acc_in;
         for (int b = 0; b < lsd_pkg::RADIX; b++) count_ff[b] <= count_in[b];
      end
   end

endmodule
`default_nettype wire

### hw/rtl/lsd_radix_sort_decimal.sv
// Decimal LSD radix sorter for keyed records.
// Input channel (req_*): one record per transaction, a 31-bit key, a tag and
// a last mark. Records load one per cycle while the block is in its load
// phase; records beyond MAX_RECORDS are dropped, but their last mark counts.
// A transaction with the last mark starts the sort; req_stall stays high
// until the last sorted record has been placed in the output register.
// The sort makes one stable pass per decimal digit of the largest key (D
// passes, 1 to 10). Each pass sweeps the N held records twice through the
// two record memories (count, then scatter, ping-ponging between them) and
// scans the ten bucket counters once. Results (rsp_*) then leave in
// ascending key order, ties in arrival order, one at a time: each is read
// from memory, then placed in the output register, and end_of_run marks
// the final one.
// rsp_stall holds the output register; the emit sequence waits on it.
// A new set may start loading while the final result still waits.
// Reset (synchronous) empties the block; memory contents are not cleared.
`default_nettype none
module lsd_radix_sort_decimal #(
   parameter int MAX_RECORDS = 64,
   parameter int TAG_BITS    = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lsd_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lsd_pkg::rsp_type      rsp_data
);

   localparam int KW = lsd_pkg::KEY_W;
   localparam int DW = lsd_pkg::DIG_W;
   localparam int TW = (TAG_BITS < lsd_pkg::TAG_W) ? TAG_BITS : lsd_pkg::TAG_W;
   localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CW = $clog2(MAX_RECORDS + 1);
   localparam int IW = ($clog2(MAX_RECORDS + 2) > DW) ? $clog2(MAX_RECORDS + 2) : DW;
   localparam int PW = KW + TW;       // key and tag
   localparam int EW = PW + KW;       // plus running quotient

   lsd_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [DW-1:0]  ldc_ff, ldc_in;
   logic [DW-1:0]  pass_ff, pass_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic           rd_valid_ff;
   lsd_pkg::rsp_type rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic           a_we, b_we, rd_en, rd_sel;
   logic [AW-1:0]  waddr, raddr;
   logic [EW-1:0]  wdata, a_rdata, b_rdata, rdata;

   logic           dig_valid;
   logic [DW-1:0]  dig_digit, new_digits;
   logic [KW-1:0]  dig_q;
   logic [PW-1:0]  dig_pay;
   logic [CW-1:0]  start_val;
   lsd_pkg::bkt_ctl_type bctl;
   logic           emit_take, emit_last;

   // Record memories, used in turn as source and destination
   lsd_ram #(.WIDTH(EW), .DEPTH(MAX_RECORDS)) u_ram_a (
      .clock(clock), .we(a_we), .waddr(waddr), .wdata(wdata),
      .re(rd_en), .raddr(raddr), .rdata(a_rdata)
   );

   lsd_ram #(.WIDTH(EW), .DEPTH(MAX_RECORDS)) u_ram_b (
      .clock(clock), .we(b_we), .waddr(waddr), .wdata(wdata),
      .re(rd_en), .raddr(raddr), .rdata(b_rdata)
   );

   assign rdata = rd_sel ? b_rdata : a_rdata;

   lsd_digit #(.PW(PW)) u_digit (
      .clock(clock), .reset(reset),
      .in_valid(rd_valid_ff), .in_q(rdata[KW-1:0]), .in_pay(rdata[EW-1:KW]),
      .out_valid(dig_valid), .out_digit(dig_digit), .out_q(dig_q), .out_pay(dig_pay)
   );

   lsd_bucket #(.CW(CW)) u_bucket (
      .clock(clock), .reset(reset), .ctl(bctl), .start_val(start_val)
   );

   assign new_digits = lsd_pkg::digits_of(req_data.sort_key);
   assign req_stall  = (state_ff != lsd_pkg::ST_LOAD);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Sequencer: load, then per digit count / prefix / scatter, then emit
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ldc_in       = ldc_ff;
      pass_in      = pass_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      a_we         = 1'b0;
      b_we         = 1'b0;
      waddr        = '0;
      wdata        = '0;
      rd_en        = 1'b0;
      raddr        = AW'(idx_ff);
      rd_sel       = pass_ff[0];
      bctl         = '0;
      emit_take    = 1'b0;
      emit_last    = 1'b0;

      case (state_ff)
         lsd_pkg::ST_LOAD: begin
            if (req_valid) begin
               if (cnt_ff < CW'(MAX_RECORDS)) begin
                  a_we   = 1'b1;
                  waddr  = AW'(cnt_ff);
                  wdata  = {req_data.sort_key, TW'(req_data.record_tag),
                            req_data.sort_key};
                  cnt_in = cnt_ff + CW'(1);
                  if (new_digits > ldc_ff) ldc_in = new_digits;
               end
               if (req_data.is_last) begin
                  state_in   = lsd_pkg::ST_COUNT;
                  idx_in     = '0;
                  pass_in    = '0;
                  bctl.clear = 1'b1;
               end
            end
         end

         lsd_pkg::ST_COUNT: begin
            rd_en  = (idx_ff < IW'(cnt_ff));
            idx_in = idx_ff + IW'(1);
            if (dig_valid) begin
               bctl.bump = 1'b1;
               bctl.sel  = dig_digit;
            end
            if (idx_ff == IW'(cnt_ff) + IW'(1)) begin
               state_in = lsd_pkg::ST_PREFIX;
               idx_in   = '0;
            end
         end

         lsd_pkg::ST_PREFIX: begin
            bctl.scan = 1'b1;
            bctl.sel  = DW'(idx_ff);
            idx_in    = idx_ff + IW'(1);
            if (idx_ff == IW'(lsd_pkg::RADIX - 1)) begin
               state_in = lsd_pkg::ST_SCATTER;
               idx_in   = '0;
            end
         end

         lsd_pkg::ST_SCATTER: begin
            rd_en  = (idx_ff < IW'(cnt_ff));
            idx_in = idx_ff + IW'(1);
            if (dig_valid) begin
               bctl.bump = 1'b1;
               bctl.sel  = dig_digit;
               a_we      = pass_ff[0];
               b_we      = ~pass_ff[0];
               waddr     = AW'(start_val);
               wdata     = {dig_pay, dig_q};
            end
            if (idx_ff == IW'(cnt_ff) + IW'(1)) begin
               idx_in = '0;
               if (pass_ff + DW'(1) == ldc_ff) begin
                  state_in = lsd_pkg::ST_EMIT_RD;
               end else begin
                  state_in   = lsd_pkg::ST_COUNT;
                  pass_in    = pass_ff + DW'(1);
                  bctl.clear = 1'b1;
               end
            end
         end

         lsd_pkg::ST_EMIT_RD: begin
            rd_sel   = ldc_ff[0];
            rd_en    = 1'b1;
            state_in = lsd_pkg::ST_EMIT_LD;
         end

         lsd_pkg::ST_EMIT_LD: begin
            rd_sel    = ldc_ff[0];
            emit_last = (idx_ff + IW'(1) == IW'(cnt_ff));
            if (!rsp_valid_ff || !rsp_stall) begin
               emit_take         = 1'b1;
               rsp_in.sorted_key = rdata[EW-1 -: KW];
               rsp_in.sorted_tag = lsd_pkg::TAG_W'(rdata[KW +: TW]);
               rsp_in.end_of_run = emit_last;
               rsp_valid_in      = 1'b1;
               if (emit_last) begin
                  state_in = lsd_pkg::ST_LOAD;
                  cnt_in   = '0;
                  ldc_in   = '0;
                  idx_in   = '0;
               end else begin
                  state_in = lsd_pkg::ST_EMIT_RD;
                  idx_in   = idx_ff + IW'(1);
               end
            end
         end

         default: begin
            state_in = lsd_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsd_pkg::ST_LOAD;
         cnt_ff       <= '0;
         ldc_ff       <= '0;
         pass_ff      <= '0;
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ldc_ff       <= ldc_in;
         pass_ff      <= pass_in;
         idx_ff       <= idx_in;
         rd_valid_ff  <= rd_en && (state_ff != lsd_pkg::ST_EMIT_RD);
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // Scatter slots stay inside the held records
   a_scatter_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsd_pkg::ST_SCATTER && dig_valid) |-> (start_val < cnt_ff))
      else $error("scatter slot beyond record count");

   // Digit extractor yields a decimal digit
   a_digit_decimal: assert property (@(posedge clock) disable iff (reset)
      dig_valid |-> (dig_digit < DW'(lsd_pkg::RADIX)))
      else $error("digit out of range");

   // Sorting only with records held and a digit count set
   a_sort_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != lsd_pkg::ST_LOAD) |->
         (cnt_ff != '0 && ldc_ff != '0 && ldc_ff <= DW'(lsd_pkg::MAX_DIGITS)))
      else $error("sort running without records");

   // Final result empties the store and flags end of run
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (emit_take && emit_last) |=>
         (state_ff == lsd_pkg::ST_LOAD && cnt_ff == '0 && rsp_valid_ff &&
          rsp_ff.end_of_run))
      else $error("run did not close cleanly");

endmodule
`default_nettype wire
